FILE: hw/rtl/nsf_pkg.sv
// nsf_pkg: shared constants, types and helper functions of the nmea sentence framer
// no dependencies; used by the interfaces, nsf_tracker and nmea_sentence_framer
package nsf_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam int HEX_RADIX = 16;
    localparam int TYPE_COUNT = 8;

    localparam logic [7:0] MAX_LENGTH_RESET = 8'd82;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic MAX_LENGTH_WORD = 1'b0;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SHORT    = 2'd1;
    localparam logic [1:0] STATUS_BAD_HEX  = 2'd2;
    localparam logic [1:0] STATUS_MISMATCH = 2'd3;

    localparam logic [23:0] TYPE_NAMES [TYPE_COUNT] = '{
        {8'h47, 8'h47, 8'h41},  // GGA
        {8'h52, 8'h4D, 8'h43},  // RMC
        {8'h47, 8'h53, 8'h41},  // GSA
        {8'h56, 8'h54, 8'h47},  // VTG
        {8'h48, 8'h44, 8'h54},  // HDT
        {8'h41, 8'h50, 8'h42},  // APB
        {8'h41, 8'h41, 8'h4D},  // AAM
        {8'h47, 8'h53, 8'h56}   // GSV
    };

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] computed_sum;
        logic [3:0] sentence_type;
        logic [7:0] sentence_length;
    } nsf_report_t;

    // bit 4 set when the character is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'(HEX_RADIX);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 5'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 5'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 5'(c - 8'h57);
        end
        return v;
    endfunction

    function automatic logic [3:0] type_code(input logic [23:0] tail);
        logic [3:0] code;
        code = 4'd0;
        for (int i = 0; i < TYPE_COUNT; i++)
        begin
            if (tail == TYPE_NAMES[i])
            begin
                code = 4'(i + 1);
            end
        end
        return code;
    endfunction

endpackage

FILE: hw/rtl/nsf_if.sv
// nsf_byte_if and nsf_result_if: valid/ready channels of the nmea sentence framer
// depends on nsf_pkg
interface nsf_byte_if
    import nsf_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

interface nsf_result_if
    import nsf_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] computed_sum;
    logic [3:0] sentence_type;
    logic [7:0] sentence_length;

    modport source (
        output valid, output status, output computed_sum,
        output sentence_type, output sentence_length, input ready
    );
    modport sink (
        input valid, input status, input computed_sum,
        input sentence_type, input sentence_length, output ready
    );
endinterface

FILE: hw/rtl/nsf_tracker.sv
// nsf_tracker: per-sentence state (length, running xor, star, check digits, header tail)
// depends on nsf_pkg; instantiated by nmea_sentence_framer
module nsf_tracker
    import nsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  byte_in,
    input  logic [7:0]  max_length,
    output logic        report_valid,
    output nsf_report_t report
);

    logic       open_reg, open_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] xor_reg, xor_next;
    logic       star_reg, star_next;
    logic [1:0] after_reg, after_next;
    logic [7:0] check_reg [2];
    logic [7:0] check_next [2];
    logic [7:0] tail_reg [3];
    logic [7:0] tail_next [3];
    logic       ffd_reg, ffd_next;

    logic       is_term;
    logic [4:0] hi_val;
    logic [4:0] lo_val;
    logic [7:0] expected;

    assign is_term = (byte_in == CH_CR) || (byte_in == CH_LF);

    // report from the state held before the terminator
    always_comb
    begin
        hi_val = hex_value(check_reg[0]);
        lo_val = hex_value(check_reg[1]);
        expected = lo_val[4] ? {4'd0, hi_val[3:0]} : {hi_val[3:0], lo_val[3:0]};
        if (!star_reg || after_reg < 2'd2)
        begin
            report.status = STATUS_SHORT;
        end
        else if (hi_val[4])
        begin
            report.status = STATUS_BAD_HEX;
        end
        else if (expected == xor_reg)
        begin
            report.status = STATUS_OK;
        end
        else
        begin
            report.status = STATUS_MISMATCH;
        end
        report.computed_sum = xor_reg;
        report.sentence_type = type_code({tail_reg[0], tail_reg[1], tail_reg[2]});
        report.sentence_length = count_reg;
    end

    assign report_valid = take && is_term && open_reg;

    always_comb
    begin
        open_next = open_reg;
        count_next = count_reg;
        xor_next = xor_reg;
        star_next = star_reg;
        after_next = after_reg;
        check_next = check_reg;
        tail_next = tail_reg;
        ffd_next = ffd_reg;
        if (take)
        begin
            if (byte_in == CH_DOLLAR || is_term || (open_reg && count_reg >= max_length))
            begin
                // new sentence, close, or overlong discard
                open_next = (byte_in == CH_DOLLAR);
                count_next = (byte_in == CH_DOLLAR) ? 8'd1 : 8'd0;
                xor_next = 8'd0;
                star_next = 1'b0;
                after_next = 2'd0;
                check_next[0] = 8'd0;
                check_next[1] = 8'd0;
                tail_next[0] = 8'd0;
                tail_next[1] = 8'd0;
                tail_next[2] = (byte_in == CH_DOLLAR) ? byte_in : 8'd0;
                ffd_next = 1'b0;
            end
            else if (open_reg)
            begin
                count_next = count_reg + 8'd1;
                if (!ffd_reg)
                begin
                    if (byte_in == CH_COMMA || byte_in == CH_STAR)
                    begin
                        ffd_next = 1'b1;
                    end
                    else
                    begin
                        tail_next[0] = tail_reg[1];
                        tail_next[1] = tail_reg[2];
                        tail_next[2] = byte_in;
                    end
                end
                if (!star_reg)
                begin
                    if (byte_in == CH_STAR)
                    begin
                        star_next = 1'b1;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ byte_in;
                    end
                end
                else if (after_reg < 2'd2)
                begin
                    check_next[after_reg[0]] = byte_in;
                    after_next = after_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            count_reg <= 8'd0;
            xor_reg <= 8'd0;
            star_reg <= 1'b0;
            after_reg <= 2'd0;
            check_reg[0] <= 8'd0;
            check_reg[1] <= 8'd0;
            tail_reg[0] <= 8'd0;
            tail_reg[1] <= 8'd0;
            tail_reg[2] <= 8'd0;
            ffd_reg <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
            count_reg <= count_next;
            xor_reg <= xor_next;
            star_reg <= star_next;
            after_reg <= after_next;
            check_reg <= check_next;
            tail_reg <= tail_next;
            ffd_reg <= ffd_next;
        end
    end

    a_closed_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> (count_reg == 8'd0 && !star_reg && xor_reg == 8'd0))
        else $error("closed sentence holds state");

    a_after_needs_star: assert property (@(posedge clk) disable iff (!rst_n)
        after_reg != 2'd0 |-> star_reg && after_reg <= 2'd2)
        else $error("check digits counted without star");

    a_dollar_opens: assert property (@(posedge clk) disable iff (!rst_n)
        take && byte_in == CH_DOLLAR |=> open_reg && count_reg == 8'd1)
        else $error("dollar did not open a sentence");

    a_star_ends_field: assert property (@(posedge clk) disable iff (!rst_n)
        star_reg |-> ffd_reg)
        else $error("star seen with first field still open");

endmodule

FILE: hw/rtl/nmea_sentence_framer.sv
// nmea_sentence_framer: one character per cycle in; a terminator of an open sentence
// yields one report in the result register the next cycle
// throughput one character per cycle, as nsf_tracker updates its state for every character taken;
// input stalls only while a report waits in the result register and is not taken
// rst_n is asynchronous active low: no sentence open, no report pending, max_length = 82
// depends on nsf_pkg, nsf_if and nsf_tracker
module nmea_sentence_framer
    import nsf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    nsf_byte_if.sink              byte_chan,
    nsf_result_if.source          result_chan
);

    logic [7:0]  max_length_reg;
    logic        result_valid_reg, result_valid_next;
    nsf_report_t result_reg;
    logic        take;
    logic        report_valid;
    nsf_report_t report;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == MAX_LENGTH_WORD) ? {24'd0, max_length_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == MAX_LENGTH_WORD)
        begin
            max_length_reg <= pwdata[7:0];
        end
    end

    assign byte_chan.ready = !result_valid_reg || result_chan.ready;
    assign take = byte_chan.valid && byte_chan.ready;

    nsf_tracker u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .byte_in      (byte_chan.byte_in),
        .max_length   (max_length_reg),
        .report_valid (report_valid),
        .report       (report)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (report_valid)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_chan.ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (report_valid)
        begin
            result_reg <= report;
        end
    end

    assign result_chan.valid = result_valid_reg;
    assign result_chan.status = result_reg.status;
    assign result_chan.computed_sum = result_reg.computed_sum;
    assign result_chan.sentence_type = result_reg.sentence_type;
    assign result_chan.sentence_length = result_reg.sentence_length;

    a_report_lands: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |=> result_valid_reg)
        else $error("report lost");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_chan.ready |-> !report_valid)
        else $error("pending report overwritten");

    a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> report.sentence_length != 8'd0)
        else $error("report with empty sentence");

endmodule

FILE: bench/nmea_sentence_framer_checker.sv
// nmea_sentence_framer_checker: watches the byte, result and register ports of the framer,
// keeps its own copy of the sentence state and compares every report with its prediction
// depends on nsf_pkg and the channel interfaces in nsf_if
`timescale 1ns / 100ps
module nmea_sentence_framer_checker
    import nsf_pkg::*;
#(
    parameter logic [APB_ADDR_W-1:0] LIMIT_ADDR = '0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    nsf_byte_if                   byte_chan,
    nsf_result_if                 result_chan,
    output int                    fail_count,
    output int                    reports_due
);

    typedef enum logic [3:0] {
        TY_OTHER, TY_GGA, TY_RMC, TY_GSA, TY_VTG, TY_HDT, TY_APB, TY_AAM, TY_GSV
    } nmea_type_e;

    logic [7:0]  length_limit;
    logic        in_frame;
    logic [7:0]  frame_len;
    logic [7:0]  run_sum;
    logic        star_hit;
    logic [1:0]  digits_seen;
    logic [7:0]  digits [2];
    logic [7:0]  head_tail [3];
    logic        head_done;
    nsf_report_t expected_reports [$];
    int          mismatches = 0;
    int          due_count = 0;

    assign fail_count  = mismatches;
    assign reports_due = due_count;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c) - int'("0");
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c) - int'("A") + 10;
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c) - int'("a") + 10;
        end
        return -1;
    endfunction

    function automatic logic [1:0] judge_sum();
        int hi;
        int lo;
        int want;
        if (!star_hit || digits_seen < 2)
        begin
            return STATUS_SHORT;
        end
        hi = nibble_of(digits[0]);
        if (hi < 0)
        begin
            return STATUS_BAD_HEX;
        end
        lo = nibble_of(digits[1]);
        want = (lo < 0) ? hi : hi * HEX_RADIX + lo;
        return (want == int'(run_sum)) ? STATUS_OK : STATUS_MISMATCH;
    endfunction

    function automatic nmea_type_e classify();
        case ({head_tail[0], head_tail[1], head_tail[2]})
            "GGA": return TY_GGA;
            "RMC": return TY_RMC;
            "GSA": return TY_GSA;
            "VTG": return TY_VTG;
            "HDT": return TY_HDT;
            "APB": return TY_APB;
            "AAM": return TY_AAM;
            "GSV": return TY_GSV;
            default: return TY_OTHER;
        endcase
    endfunction

    task automatic clear_frame();
        in_frame    = 1'b0;
        frame_len   = '0;
        run_sum     = '0;
        star_hit    = 1'b0;
        digits_seen = '0;
        digits      = '{default: '0};
        head_tail   = '{default: '0};
        head_done   = 1'b0;
    endtask

    task automatic frame_char(input logic [7:0] c);
        nsf_report_t rep;
        if (c == CH_DOLLAR)
        begin
            clear_frame();
            in_frame = 1'b1;
            frame_len = 8'd1;
            head_tail[2] = c;
        end
        else if (c == CH_CR || c == CH_LF)
        begin
            if (in_frame)
            begin
                rep.status          = judge_sum();
                rep.computed_sum    = run_sum;
                rep.sentence_type   = classify();
                rep.sentence_length = frame_len;
                expected_reports.push_back(rep);
            end
            clear_frame();
        end
        else if (in_frame)
        begin
            if (frame_len >= length_limit)
            begin
                // overlong sentence dropped without a report
                clear_frame();
            end
            else
            begin
                frame_len++;
                if (!head_done)
                begin
                    if (c == CH_COMMA || c == CH_STAR)
                    begin
                        head_done = 1'b1;
                    end
                    else
                    begin
                        head_tail[0] = head_tail[1];
                        head_tail[1] = head_tail[2];
                        head_tail[2] = c;
                    end
                end
                if (!star_hit)
                begin
                    if (c == CH_STAR)
                    begin
                        star_hit = 1'b1;
                    end
                    else
                    begin
                        run_sum ^= c;
                    end
                end
                else if (digits_seen < 2)
                begin
                    digits[digits_seen[0]] = c;
                    digits_seen++;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        nsf_report_t want;
        if (!rst_n)
        begin
            clear_frame();
            length_limit = MAX_LENGTH_RESET;
            expected_reports.delete();
        end
        else
        begin
            if (result_chan.valid && result_chan.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report with no sentence pending: status %0d sum %0d length %0d",
                        result_chan.status, result_chan.computed_sum,
                        result_chan.sentence_length);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("status", want.status, result_chan.status);
                    check_field("computed_sum", want.computed_sum, result_chan.computed_sum);
                    check_field("sentence_type", want.sentence_type, result_chan.sentence_type);
                    check_field("sentence_length", want.sentence_length,
                        result_chan.sentence_length);
                end
            end
            if (byte_chan.valid && byte_chan.ready)
            begin
                frame_char(byte_chan.byte_in);
            end
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
            begin
                length_limit = pwdata[7:0];
            end
        end
        due_count = expected_reports.size();
    end

endmodule

FILE: bench/nmea_sentence_framer_tb.sv
// nmea_sentence_framer_tb: drives sentences, noise and register writes into the framer
// under several idle and stall patterns; reports are checked by nmea_sentence_framer_checker
// depends on nsf_pkg, nsf_if, nmea_sentence_framer and nmea_sentence_framer_checker
`timescale 1ns / 100ps
module nmea_sentence_framer_tb;
    import nsf_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_LENGTH =
        APB_ADDR_W'(4 * int'(MAX_LENGTH_WORD));

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int reports_due;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holds_asked = 0;
    int sent_bytes = 0;
    int quiet_cycles = 0;

    string      type_names [8] = '{"GGA", "RMC", "GSA", "VTG", "HDT", "APB", "AAM", "GSV"};
    string      talker_ids [4] = '{"GP", "GN", "II", "HE"};
    string      field_chars = "0123456789.NSEWMABCDEFabcdef-";
    string      odd_chars = "/:@G`gZz!";
    logic [7:0] marks [5] = '{CH_DOLLAR, CH_CR, CH_LF, CH_STAR, CH_COMMA};

    nsf_byte_if   byte_chan ();
    nsf_result_if result_chan ();

    nmea_sentence_framer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .byte_chan   (byte_chan),
        .result_chan (result_chan)
    );

    nmea_sentence_framer_checker #(
        .LIMIT_ADDR (ADDR_MAX_LENGTH)
    ) frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .byte_chan   (byte_chan),
        .result_chan (result_chan),
        .fail_count  (fail_count),
        .reports_due (reports_due)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if ((byte_chan.valid && byte_chan.ready) || (result_chan.valid && result_chan.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // report receiver: random stalls plus the long hold-off when one is asked for
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left = 0;
        holds_done = 0;
        result_chan.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_chan.ready = 1'b0;
            end
            else if (holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = LONG_HOLD - 1;
                result_chan.ready = 1'b0;
            end
            else
            begin
                result_chan.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
        begin
            return 8'("0") + 8'(n);
        end
        return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(255));
        end
        while (b == CH_DOLLAR || b == CH_CR || b == CH_LF);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_chan.valid = 1'b0;
            @(negedge clk);
        end
        byte_chan.valid = 1'b1;
        byte_chan.byte_in = b;
        @(posedge clk);
        while (!byte_chan.ready)
        begin
            @(posedge clk);
        end
        sent_bytes++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    task automatic wait_drained();
        byte_chan.valid = 1'b0;
        while (reports_due != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic emit_sentence();
        logic [7:0] frame [$];
        logic [7:0] sum;
        logic [7:0] told;
        string      tag;
        int         pick;
        int         len_goal;
        frame.push_back(CH_DOLLAR);
        pick = $urandom_range(9);
        if (pick < 8)
        begin
            tag = {talker_ids[2'($urandom_range(3))], type_names[3'($urandom_range(7))]};
            for (int i = 0; i < tag.len(); i++)
            begin
                frame.push_back(tag[i]);
            end
        end
        else if (pick == 8)
        begin
            repeat ($urandom_range(1, 5))
            begin
                frame.push_back(8'($urandom_range("A", "Z")));
            end
        end
        else
        begin
            repeat ($urandom_range(0, 4))
            begin
                frame.push_back(body_byte());
            end
        end
        repeat ($urandom_range(0, 5))
        begin
            frame.push_back(CH_COMMA);
            repeat ($urandom_range(0, 8))
            begin
                frame.push_back(field_chars[$urandom_range(field_chars.len() - 1)]);
            end
        end
        if ($urandom_range(24) == 0)
        begin
            len_goal = $urandom_range(230, 265);
            while (frame.size() < len_goal)
            begin
                frame.push_back("0");
            end
        end
        sum = '0;
        for (int i = 1; i < frame.size(); i++)
        begin
            sum ^= frame[i];
        end
        pick = $urandom_range(99);
        told = (pick >= 62 && pick < 70) ? sum ^ 8'($urandom_range(1, 255)) : sum;
        if (pick < 70 || pick >= 91)
        begin
            frame.push_back(CH_STAR);
            frame.push_back(hex_char(told[7:4], 1'($urandom_range(1))));
            frame.push_back(hex_char(told[3:0], 1'($urandom_range(1))));
            if (pick >= 91)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    frame.push_back(($urandom_range(2) == 0) ? CH_STAR : body_byte());
                end
            end
        end
        else if (pick >= 76 && pick < 81)
        begin
            frame.push_back(CH_STAR);
            frame.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        end
        else if (pick >= 81 && pick < 86)
        begin
            frame.push_back(CH_STAR);
            frame.push_back(odd_chars[$urandom_range(odd_chars.len() - 1)]);
            frame.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        end
        else if (pick >= 86)
        begin
            // second digit not hex, so the first one alone is compared
            frame.push_back(CH_STAR);
            frame.push_back(hex_char(sum[3:0], 1'($urandom_range(1))));
            frame.push_back(odd_chars[$urandom_range(odd_chars.len() - 1)]);
        end
        pick = $urandom_range(9);
        if (pick >= 1 && pick < 5)
        begin
            frame.push_back(CH_CR);
        end
        else if (pick >= 5 && pick < 8)
        begin
            frame.push_back(CH_LF);
        end
        else if (pick >= 8)
        begin
            frame.push_back(CH_CR);
            frame.push_back(CH_LF);
        end
        foreach (frame[i])
        begin
            send_byte(frame[i]);
        end
    endtask

    task automatic emit_noise();
        repeat ($urandom_range(1, 10))
        begin
            if ($urandom_range(3) == 0)
            begin
                send_byte(marks[3'($urandom_range(4))]);
            end
            else
            begin
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_phase(input int limit, input int idle_pct, input int stall_pct,
                             input int budget, input bit long_hold);
        int stop_at;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(ADDR_MAX_LENGTH, APB_DATA_W'(limit));
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        if (long_hold)
        begin
            holds_asked++;
        end
        stop_at = sent_bytes + budget;
        while (sent_bytes < stop_at)
        begin
            if ($urandom_range(4) == 0)
            begin
                emit_noise();
            end
            else
            begin
                emit_sentence();
            end
        end
    endtask

    initial
    begin
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        byte_chan.valid = 1'b0;
        byte_chan.byte_in = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // terminator with nothing open, then short, well-formed, mismatching and bad-hex sentences
        send_byte(CH_LF);
        send_text("$\r");
        send_text("$HDT*58\n");
        send_text("$A,*0\r");
        send_byte(CH_DOLLAR);
        send_byte(8'hFF);
        send_text("*fZ\n");
        send_text("$*G0\r");

        run_phase(8, 0, 0, 250, 1'b0);
        run_phase(255, 87, 0, 350, 1'b0);
        run_phase(82, 0, 87, 350, 1'b0);
        run_phase($urandom_range(20, 60), 36, 36, 350, 1'b0);
        run_phase(6, 0, 0, 100, 1'b0);
        run_phase(82, 0, 0, 300, 1'b1);
        run_phase($urandom_range(8, 255), 36, 36, 250, 1'b0);

        wait_drained();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
